[rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared field widths and reset constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Field widths of one transaction
  localparam int unsigned BASE_W     = 31;
  localparam int unsigned EXP_W      = 31;
  localparam int unsigned POW_W      = 31;
  localparam int unsigned MODCFG_W   = 31;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  // Modulus after reset (1e9 + 7)
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage : mexp_pkg

`default_nettype wire

[rtl/mexp_mulser.sv]
// ----------------------------------------------------------------------------
// mexp_mulser
// Bit-serial interleaved modular multiplier: p = x * y mod m, one bit of x
// per cycle, most significant bit first. Requires y < m.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulser #(
  parameter int unsigned W  = 31,
  parameter int unsigned XW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  input  wire logic [W-1:0]  y,
  input  wire logic [W-1:0]  m,
  output logic               done,
  output logic [W-1:0]       p
);

  localparam int unsigned CW = $clog2(XW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  r_r, r_nxt;

  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W-1:0]  r_red;

  // Double the partial result, add the multiplicand on a set bit, reduce below m
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, r_r, 1'b0} + (x_r[XW-1] ? {2'b00, y_r} : {(W+2){1'b0}});
    if (t >= m2) begin
      r_red = W'(t - m2);
    end else if (t >= m1) begin
      r_red = W'(t - m1);
    end else begin
      r_red = W'(t);
    end
  end

  // Load on start, then shift one multiplier bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(XW);
      x_nxt    = x;
      y_nxt    = y;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = r_red;
      x_nxt   = {x_r[XW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign p    = r_r;

endmodule : mexp_mulser

`default_nettype wire

[rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary square-and-multiply: power = base^exponent mod modulus.
// ----------------------------------------------------------------------------
// One transaction at a time. Two bit-serial modular multipliers run side by
// side, one squaring and one multiplying, each taking one bit of its operand
// per cycle (XW = max(MOD_BITS, 31) bits per pass). The base is first reduced
// in one pass, then one pass runs per exponent bit up to its highest set bit
// L, L + 2 passes in all. An exponent of zero still takes the base pass; a
// modulus of zero skips the passes and goes straight to the result. A new
// transaction is taken once the result sits in the output register, even
// before it is consumed.
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned MOD_BITS = 31
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: base [30:0], exponent [61:31], zero [63:62]
  input  wire logic [mexp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // out_tdata: power [30:0], zero [31]
  output logic [mexp_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [mexp_pkg::MODCFG_W-1:0]        cfg_wr_data
);

  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned XW = (MOD_BITS > mexp_pkg::BASE_W) ? MOD_BITS : mexp_pkg::BASE_W;
  localparam int unsigned EW = mexp_pkg::EXP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BASE = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sq_r, sq_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [mexp_pkg::POW_W-1:0] out_pow_r, out_pow_nxt;

  logic [mexp_pkg::BASE_W-1:0] in_base;
  logic [EW-1:0] in_exp;
  logic          in_fire;
  logic [W-1:0]  one_m;

  logic          mul_a_start, mul_b_start;
  logic [XW-1:0] mul_a_x, mul_b_x;
  logic [W-1:0]  mul_a_y, mul_b_y;
  logic          mul_a_done, mul_b_done;
  logic [W-1:0]  mul_a_p, mul_b_p;

  // Unpack the input transaction
  assign in_base   = in_tdata[mexp_pkg::BASE_W-1:0];
  assign in_exp    = in_tdata[mexp_pkg::BASE_W+EW-1:mexp_pkg::BASE_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign one_m     = (mod_r == W'(1)) ? '0 : W'(1);

  // Modulus register
  always_comb begin
    mod_nxt = mod_r;
    if (cfg_wr_en) begin
      mod_nxt = W'(cfg_wr_data);
    end
  end

  // Sequencer: reduce base, then one square and multiply pass per exponent bit
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r;
    out_pow_nxt   = out_pow_r;
    mul_a_start   = 1'b0;
    mul_b_start   = 1'b0;
    mul_a_x       = XW'(in_base);
    mul_a_y       = one_m;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          e_nxt   = in_exp;
          acc_nxt = one_m;
          if (mod_r == '0) begin
            acc_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            mul_a_start = 1'b1;
            state_nxt   = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mul_a_done) begin
          sq_nxt = mul_a_p;
          if (e_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            mul_a_start = 1'b1;
            mul_b_start = 1'b1;
            state_nxt   = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (mul_a_done) begin
          sq_nxt = mul_a_p;
          if (e_r[0]) begin
            acc_nxt = mul_b_p;
          end
          e_nxt = e_r >> 1;
          if (e_nxt == '0) begin
            state_nxt = S_FIN;
          end else begin
            mul_a_start = 1'b1;
            mul_b_start = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pow_nxt   = mexp_pkg::POW_W'(acc_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Operands for the next pass come from the freshly updated values
    if (state_r != S_IDLE) begin
      mul_a_x = XW'(sq_nxt);
      mul_a_y = sq_nxt;
    end
  end

  assign mul_b_x = XW'(acc_nxt);
  assign mul_b_y = sq_nxt;

  // Squaring unit, also used to reduce the base
  mexp_mulser #(
    .W  (W),
    .XW (XW)
  ) u_mul_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_a_start),
    .x     (mul_a_x),
    .y     (mul_a_y),
    .m     (mod_r),
    .done  (mul_a_done),
    .p     (mul_a_p)
  );

  // Accumulating multiply unit
  mexp_mulser #(
    .W  (W),
    .XW (XW)
  ) u_mul_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_b_start),
    .x     (mul_b_x),
    .y     (mul_b_y),
    .m     (mod_r),
    .done  (mul_b_done),
    .p     (mul_b_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= W'(mexp_pkg::MODULUS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    out_pow_r <= out_pow_nxt;
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = mexp_pkg::OUT_TDATA_W'(out_pow_r);

  // Both multipliers finish together during the exponent loop
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (mul_a_done == mul_b_done))
    else $error("multiplier units out of step");

  // The loop never runs with the exponent used up
  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (e_r != '0))
    else $error("exponent loop running on zero exponent");

  // The running result stays reduced
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STEP) && (mod_r != '0)) |-> (acc_r < mod_r))
    else $error("running result not reduced");

  // The finish state loads its result once the output register is free
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_tready) && (state_r == S_FIN) |=> out_valid_r)
    else $error("finished result not loaded");

endmodule : modular_exponentiation

`default_nettype wire

[sim/modular_exponentiation_test.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking testbench for the square-and-multiply exponentiation block.
// Drives base/exponent transactions with random gaps, backpressures the
// result stream at random (plus one long hold that stalls the input side),
// and compares every power against an in-bench predictor. The modulus is
// rewritten between batches, covering 0, 1, 2, the maximum and random values.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mexp_pkg::EXP_W-1:0]  exponent;
    logic [mexp_pkg::BASE_W-1:0] base;
  } exp_request_t;

  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_DEFAULT =
    mexp_pkg::MODCFG_W'(mexp_pkg::MODULUS_RESET);
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_MAX     = '1;
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_ZERO    = '0;
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_ONE     = mexp_pkg::MODCFG_W'(1);
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_TWO     = mexp_pkg::MODCFG_W'(2);
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_POW2    = mexp_pkg::MODCFG_W'(65536);
  localparam logic [mexp_pkg::MODCFG_W-1:0] MOD_SMALL   = mexp_pkg::MODCFG_W'(97);
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES  = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [mexp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [mexp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [mexp_pkg::MODCFG_W-1:0]    cfg_wr_data = '0;

  // Bench copy of the modulus register and the work queues
  logic [mexp_pkg::MODCFG_W-1:0] modulus_now = MOD_DEFAULT;
  exp_request_t                  pending_requests[$];
  logic [mexp_pkg::POW_W-1:0]    expected_powers[$];

  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  bit pressure_on = 1'b0;
  int unsigned hold_left;
  bit          hold_taken;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned requests_issued = 0;
  int unsigned powers_checked = 0;
  int unsigned modulus_settings = 1;
  int unsigned error_count = 0;

  modular_exponentiation i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // base^exponent mod modulus, right-to-left, products kept at 64 bits
  function automatic logic [mexp_pkg::POW_W-1:0] power_mod(
      input logic [mexp_pkg::BASE_W-1:0]   base,
      input logic [mexp_pkg::EXP_W-1:0]    exponent,
      input logic [mexp_pkg::MODCFG_W-1:0] modulus);
    longint unsigned m;
    longint unsigned acc;
    longint unsigned sq;
    logic [mexp_pkg::EXP_W-1:0] e;
    m = modulus;
    if (m == 0) return '0;
    acc = 1 % m;
    sq = base % m;
    e = exponent;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      e = e >> 1;
      sq = (sq * sq) % m;
    end
    return acc[mexp_pkg::POW_W-1:0];
  endfunction

  // Idle stretch length: mostly short, now and then long
  function automatic int unsigned idle_length();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [mexp_pkg::BASE_W-1:0] random_base(
      input logic [mexp_pkg::MODCFG_W-1:0] modulus);
    longint unsigned v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = 1;
      2: v = longint'(modulus) - 1;
      3: v = $urandom_range(16);
      4: v = longint'(modulus) * $urandom_range(3) + $urandom_range(2);
      default: v = $urandom();
    endcase
    return mexp_pkg::BASE_W'(v);
  endfunction

  // Exponent with a random highest set bit; keeps most runs short
  function automatic logic [mexp_pkg::EXP_W-1:0] random_exponent(input bit short_only);
    int unsigned r;
    int unsigned len;
    logic [mexp_pkg::EXP_W-1:0] e;
    r = $urandom_range(99);
    if (short_only) len = $urandom_range(4);
    else if (r < 70) len = $urandom_range(8);
    else if (r < 95) len = $urandom_range(20, 9);
    else len = $urandom_range(31, 21);
    if (len == 0) return '0;
    e = mexp_pkg::EXP_W'($urandom());
    e = e & ((mexp_pkg::EXP_W'(1) << len) - mexp_pkg::EXP_W'(1));
    e[len-1] = 1'b1;
    return e;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // Sender: present queued requests, with random gaps unless the sender is steady
  always @(posedge clk) begin : drive_input
    exp_request_t next_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_powers.push_back(power_mod(
          in_tdata[mexp_pkg::BASE_W-1:0],
          in_tdata[mexp_pkg::BASE_W+mexp_pkg::EXP_W-1:mexp_pkg::BASE_W], modulus_now));
        requests_issued++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(mexp_pkg::IN_TDATA_W-mexp_pkg::BASE_W-mexp_pkg::EXP_W){1'b0}},
                       next_req.exponent, next_req.base};
          gap_left <= (sender_steady || $urandom_range(99) < 60) ? 0 : idle_length();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, once, when the pressure batch starts
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (pressure_on && !hold_taken) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each power against the oldest expectation, stall at random
  always @(posedge clk) begin : check_output
    logic [mexp_pkg::POW_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_powers.size() == 0) begin
          $error("power %0d arrived with no transaction outstanding",
                 out_tdata[mexp_pkg::POW_W-1:0]);
          error_count++;
        end else begin
          want = expected_powers.pop_front();
          if (out_tdata[mexp_pkg::POW_W-1:0] !== want) begin
            $error("power mismatch: expected %0d, got %0d", want,
                   out_tdata[mexp_pkg::POW_W-1:0]);
            error_count++;
          end
          powers_checked++;
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (receiver_steady || $urandom_range(99) >= 20) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= idle_length() - 1;
      end
    end
  end

  // Wait until every request is out and every power is back
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_tvalid || expected_powers.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_request(input logic [mexp_pkg::BASE_W-1:0] base,
                             input logic [mexp_pkg::EXP_W-1:0] exponent);
    exp_request_t req;
    req.base = base;
    req.exponent = exponent;
    pending_requests.push_back(req);
  endtask

  // Write the modulus while idle, then run one batch of random requests
  task automatic run_batch(input logic [mexp_pkg::MODCFG_W-1:0] modulus,
                           input int unsigned count,
                           input bit short_exp, input bit steady_in, input bit steady_out);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= modulus;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    modulus_now = modulus;
    modulus_settings++;
    sender_steady = steady_in;
    receiver_steady = steady_out;
    repeat (count) add_request(random_base(modulus), random_exponent(short_exp));
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes and special cases at the reset modulus
    add_request('0, '0);
    add_request('0, mexp_pkg::EXP_W'(1));
    add_request('0, '1);
    add_request(mexp_pkg::BASE_W'(1), '1);
    add_request('1, '0);
    add_request('1, mexp_pkg::EXP_W'(1));
    add_request('1, '1);
    add_request(mexp_pkg::BASE_W'(2), mexp_pkg::EXP_W'(30));
    add_request(mexp_pkg::BASE_W'(2), mexp_pkg::EXP_W'(31));
    add_request(mexp_pkg::BASE_W'(MOD_DEFAULT), mexp_pkg::EXP_W'(5));
    add_request(mexp_pkg::BASE_W'(MOD_DEFAULT) + mexp_pkg::BASE_W'(1), '1);
    add_request(mexp_pkg::BASE_W'(MOD_DEFAULT) - mexp_pkg::BASE_W'(1), mexp_pkg::EXP_W'(2));
    add_request('1, mexp_pkg::EXP_W'(32'h4000_0000));
    add_request(mexp_pkg::BASE_W'(32'h2AAA_AAAA), mexp_pkg::EXP_W'(32'h5555_5555));
    add_request(mexp_pkg::BASE_W'(32'h5555_5555), mexp_pkg::EXP_W'(32'h2AAA_AAAA));
    add_request(mexp_pkg::BASE_W'(3), mexp_pkg::EXP_W'(MOD_DEFAULT) - mexp_pkg::EXP_W'(1));
    add_request(mexp_pkg::BASE_W'(12345), mexp_pkg::EXP_W'(1));
    repeat (300) add_request(random_base(MOD_DEFAULT), random_exponent(1'b0));
    wait_idle();

    run_batch(MOD_MAX, 250, 1'b0, 1'b0, 1'b1);
    run_batch(MOD_TWO, 100, 1'b0, 1'b1, 1'b0);
    run_batch(MOD_ZERO, 60, 1'b0, 1'b0, 1'b0);
    run_batch(MOD_ONE, 60, 1'b0, 1'b1, 1'b1);
    run_batch(MOD_POW2, 100, 1'b0, 1'b0, 1'b0);

    // Pressure: hold the output long while the sender keeps offering
    @(negedge clk);
    pressure_on = 1'b1;
    run_batch(MOD_SMALL, 80, 1'b1, 1'b1, 1'b0);
    pressure_on = 1'b0;

    repeat (3) run_batch(mexp_pkg::MODCFG_W'($urandom_range(32'h7FFF_FFFF, 2)), 180, 1'b0,
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    run_batch(MOD_DEFAULT, 150, 1'b0, 1'b0, 1'b0);

    // Any stray output during the tail counts as unexpected
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transactions (%0d powers checked) over %0d modulus settings,",
             requests_issued, powers_checked, modulus_settings);
    $display("moduli 0, 1, 2 and the maximum included, with one long output hold.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
